/* rtl/tom_pkg.sv */
// Shared constants, types and curve tables for the thermistor over-temperature monitor.
package tom_pkg;

  localparam int unsigned AdcBitsDef = 10;
  localparam int unsigned TempW      = 7;
  localparam int unsigned LimitW     = 8;
  localparam int unsigned ReportW    = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;

  // Segment math: temp = (offset - slope_mag * code) >> FracBits
  localparam int unsigned FracBits = 10;
  localparam int unsigned SlopeW   = 10;
  localparam int unsigned OffsetW  = 19;
  localparam int unsigned BrkW     = 10;
  localparam int unsigned NumSeg   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCurveSelect  = 3'd0,
    CfgFaultLimit   = 3'd1,
    CfgWarnLimit    = 3'd2,
    CfgRecoveryLimit = 3'd3,
    CfgFactoryMode  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SegSteep = 2'd0,
    SegMid   = 2'd1,
    SegFlat  = 2'd2,
    SegCold  = 2'd3
  } seg_e;

  typedef enum logic [1:0] {
    RangeCold,
    RangeSeg,
    RangeHot
  } range_e;

  typedef enum logic {
    CurveNcp  = 1'b0,
    CurveNtse = 1'b1
  } curve_e;

  // Breakpoints per curve, coldest first: at or above the first -> 0 C before the second curve's added degree.
  localparam logic [BrkW-1:0] Brk [2][4] = '{
    '{10'd900, 10'd839, 10'd715, 10'd368},
    '{10'd901, 10'd865, 10'd784, 10'd602}
  };

  localparam logic [SlopeW-1:0] SlopeMag [2][NumSeg] = '{
    '{10'd503, 10'd247, 10'd177},
    '{10'd568, 10'd316, 10'd196}
  };

  localparam logic [OffsetW-1:0] Offset [2][NumSeg] = '{
    '{19'd453245, 19'd238575, 19'd188038},
    '{19'd512568, 19'd293862, 19'd200467}
  };

  // Temperature below the last breakpoint.
  localparam logic [TempW-1:0] TempHot [2] = '{7'd120, 7'd80};

  // Second curve adds one degree at or below this point.
  localparam logic [TempW-1:0] CalibMax = 7'd39;

endpackage

/* rtl/tom_if.sv */
// Stream and configuration interfaces of the thermistor over-temperature monitor.
interface tom_in_if #(
  parameter int unsigned AdcBits = tom_pkg::AdcBitsDef
);
  logic               valid;
  logic               ready;
  logic [AdcBits-1:0] adc_code;
  logic               shutdown_latched;
  logic               link_error;
  logic               bus_busy;

  modport source (output valid, adc_code, shutdown_latched, link_error, bus_busy,
                  input ready);
  modport sink   (input valid, adc_code, shutdown_latched, link_error, bus_busy,
                  output ready);
endinterface

interface tom_out_if;
  logic                          valid;
  logic                          ready;
  logic [tom_pkg::TempW-1:0]     temperature;
  logic                          fault_flag;
  logic                          warn_flag;
  logic                          recover_flag;
  logic [tom_pkg::ReportW-1:0]   report_word;

  modport source (output valid, temperature, fault_flag, warn_flag, recover_flag,
                  report_word, input ready);
  modport sink   (input valid, temperature, fault_flag, warn_flag, recover_flag,
                  report_word, output ready);
endinterface

interface tom_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tom_pkg::CfgIdxW-1:0]  index;
  logic [tom_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/thermistor_over_temp_monitor_core.sv */
// Top level of the thermistor over-temperature monitor.
//
//  Channel  Dir  Handshake     Carries
//  cfg_i    in   valid/ready   register index, write data
//  in_i     in   valid/ready   adc_code, shutdown_latched, link_error, bus_busy
//  out_o    out  valid/ready   temperature, fault/warn/recover flags, report_word
//
// One item per cycle while out_o is not stalled; a result passes from the input
// register through conversion and flag update into the result register.
// Reset clears the limits to their defaults and the fault, recovery and report holds.
// A stalled result holds the result register; the input register still takes
// one more item, and in_i.ready follows out_o.ready once both stages are full.
// Config writes are always accepted.
module thermistor_over_temp_monitor_core #(
  parameter int unsigned AdcBits = tom_pkg::AdcBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tom_cfg_if.sink    cfg_i,
  tom_in_if.sink     in_i,
  tom_out_if.source  out_o
);
  import tom_pkg::*;

  // Configuration
  logic              curve_sel_q;
  logic [LimitW-1:0] fault_limit_q;
  logic [LimitW-1:0] warn_limit_q;
  logic [LimitW-1:0] recovery_limit_q;
  logic              factory_mode_q;

  // Input register
  logic               s1_valid_q;
  logic [AdcBits-1:0] s1_code_q;
  logic               s1_shutdown_q;
  logic               s1_link_err_q;
  logic               s1_busy_q;

  // Result register and holds
  logic               out_valid_q;
  logic [TempW-1:0]   out_temp_q;
  logic               out_warn_q;
  logic               fault_hold_q, fault_hold_d;
  logic               recover_hold_q, recover_hold_d;
  logic [ReportW-1:0] report_hold_q, report_hold_d;

  logic             out_free;
  logic             s1_adv;
  logic             in_xfer;
  logic [TempW-1:0] temp;
  logic             warn;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_sel_q      <= 1'b0;
      fault_limit_q    <= '1;
      warn_limit_q     <= '1;
      recovery_limit_q <= '0;
      factory_mode_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgCurveSelect:   curve_sel_q      <= cfg_i.data[0];
        CfgFaultLimit:    fault_limit_q    <= cfg_i.data[LimitW-1:0];
        CfgWarnLimit:     warn_limit_q     <= cfg_i.data[LimitW-1:0];
        CfgRecoveryLimit: recovery_limit_q <= cfg_i.data[LimitW-1:0];
        CfgFactoryMode:   factory_mode_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_code_q     <= in_i.adc_code;
      s1_shutdown_q <= in_i.shutdown_latched;
      s1_link_err_q <= in_i.link_error;
      s1_busy_q     <= in_i.bus_busy;
    end
  end

  tom_curve #(
    .AdcBits (AdcBits)
  ) u_curve (
    .code_i      (s1_code_q),
    .curve_sel_i (curve_sel_q),
    .temp_o      (temp)
  );

  always_comb begin
    fault_hold_d   = fault_hold_q;
    recover_hold_d = recover_hold_q;
    report_hold_d  = report_hold_q;
    warn           = (LimitW'(temp) >= warn_limit_q);

    if (LimitW'(temp) >= fault_limit_q) begin
      if (!s1_shutdown_q) begin
        fault_hold_d = 1'b1;
      end
    end else begin
      fault_hold_d = 1'b0;
    end

    if (s1_shutdown_q) begin
      recover_hold_d = (LimitW'(temp) < recovery_limit_q);
    end

    // Zero the report on link error unless in factory mode; hold while busy.
    if (factory_mode_q || !s1_link_err_q) begin
      if (!s1_busy_q) begin
        report_hold_d = ReportW'(temp);
      end
    end else begin
      report_hold_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      fault_hold_q   <= 1'b0;
      recover_hold_q <= 1'b0;
      report_hold_q  <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        fault_hold_q   <= fault_hold_d;
        recover_hold_q <= recover_hold_d;
        report_hold_q  <= report_hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_temp_q <= temp;
      out_warn_q <= warn;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.temperature  = out_temp_q;
  assign out_o.fault_flag   = fault_hold_q;
  assign out_o.warn_flag    = out_warn_q;
  assign out_o.recover_flag = recover_hold_q;
  assign out_o.report_word  = report_hold_q;

endmodule

/* rtl/tom_curve.sv */
// Piecewise-linear conversion of a thermistor code to whole degrees.
module tom_curve #(
  parameter int unsigned AdcBits = tom_pkg::AdcBitsDef
) (
  input  logic [AdcBits-1:0]        code_i,
  input  logic                      curve_sel_i,
  output logic [tom_pkg::TempW-1:0] temp_o
);
  import tom_pkg::*;

  localparam int unsigned ProdW = SlopeW + AdcBits;
  localparam int unsigned DiffW = (ProdW > OffsetW) ? ProdW : OffsetW;

  range_e             range;
  logic [1:0]         seg_idx;
  logic [ProdW-1:0]   prod;
  logic [DiffW-1:0]   offs_ext;
  logic [DiffW-1:0]   prod_ext;
  logic [DiffW-1:0]   diff;
  logic [TempW-1:0]   seg_temp;
  logic [TempW-1:0]   raw_temp;

  // Pick the segment from the breakpoints of the selected curve.
  always_comb begin
    range   = RangeSeg;
    seg_idx = 2'(SegSteep);
    if (code_i >= Brk[curve_sel_i][0]) begin
      range = RangeCold;
    end else if (code_i >= Brk[curve_sel_i][1]) begin
      seg_idx = 2'(SegSteep);
    end else if (code_i >= Brk[curve_sel_i][2]) begin
      seg_idx = 2'(SegMid);
    end else if (code_i >= Brk[curve_sel_i][3]) begin
      seg_idx = 2'(SegFlat);
    end else begin
      range = RangeHot;
    end
  end

  always_comb begin
    logic [SlopeW-1:0]  slope;
    logic [OffsetW-1:0] offs;
    slope = '0;
    offs  = '0;
    case (seg_e'(seg_idx))
      SegSteep: begin
        slope = SlopeMag[curve_sel_i][0];
        offs  = Offset[curve_sel_i][0];
      end
      SegMid: begin
        slope = SlopeMag[curve_sel_i][1];
        offs  = Offset[curve_sel_i][1];
      end
      SegFlat: begin
        slope = SlopeMag[curve_sel_i][2];
        offs  = Offset[curve_sel_i][2];
      end
      default: begin
        slope = '0;
        offs  = '0;
      end
    endcase
    prod     = ProdW'(slope) * ProdW'(code_i);
    offs_ext = DiffW'(offs);
    prod_ext = DiffW'(prod);
    // Clamp a negative line value to zero.
    diff     = (prod_ext >= offs_ext) ? '0 : (offs_ext - prod_ext);
    seg_temp = diff[FracBits +: TempW];
  end

  always_comb begin
    case (range)
      RangeCold: raw_temp = '0;
      RangeHot:  raw_temp = TempHot[curve_sel_i];
      default:   raw_temp = seg_temp;
    endcase
    if (curve_e'(curve_sel_i) == CurveNtse && raw_temp <= CalibMax) begin
      temp_o = raw_temp + TempW'(1);
    end else begin
      temp_o = raw_temp;
    end
  end

endmodule
